[src/tun_pkg.sv]
package tun_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned EDGE_W  = 17;
  localparam int unsigned PROD_W  = 34;
  localparam int unsigned CROSS_W = 35;
  localparam int unsigned MAG_W   = 35;
  localparam int unsigned HI_W    = 18;
  localparam int unsigned LO_W    = 17;
  localparam int unsigned SQ_W    = 70;
  localparam int unsigned S_W     = 68;
  localparam int unsigned FRAC_SH = 28;
  localparam int unsigned X_W     = 96;
  localparam int unsigned ROOT_W  = 48;
  localparam int unsigned REM_W   = 51;
  localparam int unsigned NUM_W   = 63;
  localparam int unsigned Q_W     = 15;
  localparam int unsigned NORM_W  = 16;
  localparam int unsigned NLANES  = 3;

  // one word moving down the square root chain
  typedef struct packed {
    logic                          valid;
    logic                          degen;
    logic [NLANES-1:0]             sign;
    logic [NLANES-1:0][MAG_W-1:0]  mag;
    logic [X_W-1:0]                x;
    logic [REM_W-1:0]              rem;
    logic [ROOT_W-1:0]             root;
  } sq_t;

  // one word moving down the divider chain
  typedef struct packed {
    logic                          valid;
    logic                          degen;
    logic [NLANES-1:0]             sign;
    logic [ROOT_W-1:0]             lq;
    logic [NLANES-1:0][NUM_W-1:0]  rem;
    logic [NLANES-1:0][Q_W-1:0]    q;
  } dv_t;

endpackage

[src/tun_sqrt_cell.sv]
module tun_sqrt_cell
  import tun_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  sq_t  d_i,
  output sq_t  d_o
);

  sq_t              d_r, d_nxt;
  logic [REM_W-1:0] rem_sh, trial;
  logic             ge;

  always_comb begin
    rem_sh = {d_i.rem[REM_W-3:0], d_i.x[X_W-1 -: 2]};
    trial  = {{(REM_W-ROOT_W-2){1'b0}}, d_i.root, 2'b01};
    ge     = rem_sh >= trial;
    d_nxt      = d_i;
    d_nxt.x    = {d_i.x[X_W-3:0], 2'b00};
    d_nxt.rem  = ge ? rem_sh - trial : rem_sh;
    d_nxt.root = {d_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r.degen <= d_nxt.degen;
      d_r.sign  <= d_nxt.sign;
      d_r.mag   <= d_nxt.mag;
      d_r.x     <= d_nxt.x;
      d_r.rem   <= d_nxt.rem;
      d_r.root  <= d_nxt.root;
    end
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (adv) begin
      d_r.valid <= d_nxt.valid;
    end
  end

  assign d_o = d_r;

endmodule

[src/tun_div_cell.sv]
module tun_div_cell
  import tun_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  dv_t  d_i,
  output dv_t  d_o
);

  dv_t              d_r, d_nxt;
  logic [NUM_W-1:0] dvs;
  logic [Q_W-1:0]   qbit;

  always_comb begin
    dvs   = {{(NUM_W-ROOT_W){1'b0}}, d_i.lq} << BIT;
    qbit  = {{(Q_W-1){1'b0}}, 1'b1} << BIT;
    d_nxt = d_i;
    for (int i = 0; i < NLANES; i++) begin
      if (d_i.rem[i] >= dvs) begin
        d_nxt.rem[i] = d_i.rem[i] - dvs;
        d_nxt.q[i]   = d_i.q[i] | qbit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r.degen <= d_nxt.degen;
      d_r.sign  <= d_nxt.sign;
      d_r.lq    <= d_nxt.lq;
      d_r.rem   <= d_nxt.rem;
      d_r.q     <= d_nxt.q;
    end
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (adv) begin
      d_r.valid <= d_nxt.valid;
    end
  end

  assign d_o = d_r;

endmodule

[src/triangle_unit_normal.sv]
// channel  direction  payload
// in_      input      three vertices, nine signed q8.8 coordinates
// out_     output     unit normal in signed q1.14 plus degenerate flag
//
// one triangle per cycle sustained while the pipe is not held waiting on out_ready
// 67 register stages: products, cross, squares, 48 square root cells (one root bit
// each), 15 divider cells (one quotient bit each) and the output register
// the whole pipe advances together; it holds only while a result waits on out_ready
// synchronous active low reset clears the valid bits only
module triangle_unit_normal
  import tun_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [COORD_W-1:0] in_vert_a_x,
  input  logic signed [COORD_W-1:0] in_vert_a_y,
  input  logic signed [COORD_W-1:0] in_vert_a_z,
  input  logic signed [COORD_W-1:0] in_vert_b_x,
  input  logic signed [COORD_W-1:0] in_vert_b_y,
  input  logic signed [COORD_W-1:0] in_vert_b_z,
  input  logic signed [COORD_W-1:0] in_vert_c_x,
  input  logic signed [COORD_W-1:0] in_vert_c_y,
  input  logic signed [COORD_W-1:0] in_vert_c_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [NORM_W-1:0] out_norm_x,
  output logic signed [NORM_W-1:0] out_norm_y,
  output logic signed [NORM_W-1:0] out_norm_z,
  output logic                     out_degenerate
);

  logic adv;

  // edges and the six cross products
  logic signed [EDGE_W-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [PROD_W-1:0] p_nxt [6];
  logic signed [PROD_W-1:0] p_r   [6];
  logic                     v1_r;

  // cross vector
  logic signed [CROSS_W-1:0] c_nxt [NLANES];
  logic signed [CROSS_W-1:0] c_r   [NLANES];
  logic                      v2_r;

  // partial products of the squares
  logic [NLANES-1:0]            sg_nxt, sg_r;
  logic [NLANES-1:0][MAG_W-1:0] mg_nxt, mg_r;
  logic [2*HI_W-1:0]            hh_nxt [NLANES];
  logic [HI_W+LO_W-1:0]         hl_nxt [NLANES];
  logic [2*LO_W-1:0]            ll_nxt [NLANES];
  logic [2*HI_W-1:0]            hh_r   [NLANES];
  logic [HI_W+LO_W-1:0]         hl_r   [NLANES];
  logic [2*LO_W-1:0]            ll_r   [NLANES];
  logic                         dg_nxt, dg_r, v3_r;

  logic [SQ_W-1:0] sq_sum;
  sq_t             sq_in;
  sq_t             sq_ch [ROOT_W+1];
  dv_t             dv_ch [Q_W+1];

  logic                     ov_r;
  logic signed [NORM_W-1:0] nx_r, ny_r, nz_r, n_nxt [NLANES];
  logic                     deg_r;

  assign adv      = !ov_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    e1x = EDGE_W'(in_vert_b_x) - EDGE_W'(in_vert_a_x);
    e1y = EDGE_W'(in_vert_b_y) - EDGE_W'(in_vert_a_y);
    e1z = EDGE_W'(in_vert_b_z) - EDGE_W'(in_vert_a_z);
    e2x = EDGE_W'(in_vert_c_x) - EDGE_W'(in_vert_a_x);
    e2y = EDGE_W'(in_vert_c_y) - EDGE_W'(in_vert_a_y);
    e2z = EDGE_W'(in_vert_c_z) - EDGE_W'(in_vert_a_z);
    p_nxt[0] = e1y * e2z;
    p_nxt[1] = e1z * e2y;
    p_nxt[2] = e1z * e2x;
    p_nxt[3] = e1x * e2z;
    p_nxt[4] = e1x * e2y;
    p_nxt[5] = e1y * e2x;
  end

  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      c_nxt[i] = CROSS_W'(p_r[2*i]) - CROSS_W'(p_r[2*i+1]);
    end
  end

  // magnitude split into high and low halves so each multiply stays small
  always_comb begin
    dg_nxt = 1'b1;
    for (int i = 0; i < NLANES; i++) begin
      sg_nxt[i] = c_r[i][CROSS_W-1];
      mg_nxt[i] = sg_nxt[i] ? MAG_W'(-c_r[i]) : MAG_W'(c_r[i]);
      hh_nxt[i] = mg_nxt[i][MAG_W-1:LO_W] * mg_nxt[i][MAG_W-1:LO_W];
      hl_nxt[i] = mg_nxt[i][MAG_W-1:LO_W] * mg_nxt[i][LO_W-1:0];
      ll_nxt[i] = mg_nxt[i][LO_W-1:0] * mg_nxt[i][LO_W-1:0];
      if (c_r[i] != '0) dg_nxt = 1'b0;
    end
  end

  always_comb begin
    sq_sum = '0;
    for (int i = 0; i < NLANES; i++) begin
      sq_sum = sq_sum + ({{(SQ_W-2*HI_W){1'b0}}, hh_r[i]} << (2*LO_W))
                      + ({{(SQ_W-HI_W-LO_W){1'b0}}, hl_r[i]} << (LO_W+1))
                      + {{(SQ_W-2*LO_W){1'b0}}, ll_r[i]};
    end
    sq_in.valid = v3_r;
    sq_in.degen = dg_r;
    sq_in.sign  = sg_r;
    sq_in.mag   = mg_r;
    sq_in.x     = {sq_sum[S_W-1:0], {FRAC_SH{1'b0}}};
    sq_in.rem   = '0;
    sq_in.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      ov_r <= dv_ch[Q_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r   <= p_nxt;
      c_r   <= c_nxt;
      sg_r  <= sg_nxt;
      mg_r  <= mg_nxt;
      hh_r  <= hh_nxt;
      hl_r  <= hl_nxt;
      ll_r  <= ll_nxt;
      dg_r  <= dg_nxt;
      nx_r  <= n_nxt[0];
      ny_r  <= n_nxt[1];
      nz_r  <= n_nxt[2];
      deg_r <= dv_ch[Q_W].degen;
    end
  end

  assign sq_ch[0] = sq_in;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d_i   (sq_ch[k]),
      .d_o   (sq_ch[k+1])
    );
  end

  always_comb begin
    dv_ch[0].valid = sq_ch[ROOT_W].valid;
    dv_ch[0].degen = sq_ch[ROOT_W].degen;
    dv_ch[0].sign  = sq_ch[ROOT_W].sign;
    dv_ch[0].lq    = sq_ch[ROOT_W].root;
    dv_ch[0].q     = '0;
    for (int i = 0; i < NLANES; i++) begin
      dv_ch[0].rem[i] = {sq_ch[ROOT_W].mag[i], {FRAC_SH{1'b0}}};
    end
  end

  // quotient bits from msb down
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    tun_div_cell #(.BIT(Q_W-1-k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d_i   (dv_ch[k]),
      .d_o   (dv_ch[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      if (dv_ch[Q_W].degen) begin
        n_nxt[i] = '0;
      end else if (dv_ch[Q_W].sign[i]) begin
        n_nxt[i] = -$signed({1'b0, dv_ch[Q_W].q[i]});
      end else begin
        n_nxt[i] = $signed({1'b0, dv_ch[Q_W].q[i]});
      end
    end
  end

  assign out_valid      = ov_r;
  assign out_norm_x     = nx_r;
  assign out_norm_y     = ny_r;
  assign out_norm_z     = nz_r;
  assign out_degenerate = deg_r;

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_norm_x == 0 && out_norm_y == 0 && out_norm_z == 0)
    else $error("degenerate word carries a nonzero normal");

  a_norm_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_norm_x >= -16384 && out_norm_x <= 16384
               && out_norm_y >= -16384 && out_norm_y <= 16384
               && out_norm_z >= -16384 && out_norm_z <= 16384)
    else $error("normal component outside unit range");

  a_nondegen_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |-> out_norm_x != 0 || out_norm_y != 0 || out_norm_z != 0)
    else $error("non degenerate word has a zero normal");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_norm_x) && $stable(out_degenerate))
    else $error("pipe moved while output stalled");

endmodule
